// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the fragment tracker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define CHK_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: property failed");

// The condition must never be true outside reset.
`define CHK_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define CHK_PROP(lbl, clk, rstn, prop)
`define CHK_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ===== hdl/ipv4fct_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4fct_pkg
// Constants, types and helper functions of the IPv4 fragment coverage tracker.
// ----------------------------------------------------------------------------
package ipv4fct_pkg;

  // Bitmap geometry.
  localparam int BITMAP_WORDS  = 128;
  localparam int BLOCK_BYTES   = 8;
  localparam int WORD_BITS     = 64;
  localparam int BITMAP_BLOCKS = BITMAP_WORDS * WORD_BITS;

  localparam int IDX_W     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int BIT_POS_W = $clog2(WORD_BITS);
  localparam int SPAN_W    = BIT_POS_W + 1;
  // Block index of a byte offset, and block bound of an exclusive end (last+1).
  localparam int LO_W      = 16 - BLK_SHIFT;
  localparam int HI_W      = 17 - BLK_SHIFT;
  localparam int WCMP_W    = HI_W - BIT_POS_W;

  // Protocol constants.
  localparam logic [15:0] UNKNOWN_LAST    = 16'hFFFF;
  localparam logic [15:0] ETH_HDR_BYTES   = 16'd14;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;

  // Item operation codes.
  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_ADD   = 1'b1
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the item fields
    logic setup;  // length checks, last byte update, scan bounds
    logic rd;     // read one bitmap word of the scan
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic op_clear;  // captured item is a clear
    logic rd_last;   // scan read pointer sits on the last word
  } ctrl_sts_t;

  // Mask with the low n bits set, n from 0 to WORD_BITS.
  function automatic logic [WORD_BITS-1:0] ones_below(input logic [SPAN_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    if (n >= SPAN_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (WORD_BITS'(1) << n[BIT_POS_W-1:0]) - WORD_BITS'(1);
    end
    return m;
  endfunction

  // Number of bits of word w that lie below a block bound given as word and bit.
  function automatic logic [SPAN_W-1:0] bound_span(input logic [WCMP_W-1:0] w,
                                                   input logic [WCMP_W-1:0] bnd_word,
                                                   input logic [BIT_POS_W-1:0] bnd_bit);
    logic [SPAN_W-1:0] s;
    if (w < bnd_word) begin
      s = SPAN_W'(WORD_BITS);
    end else if (w == bnd_word) begin
      s = {1'b0, bnd_bit};
    end else begin
      s = '0;
    end
    return s;
  endfunction

endpackage

// ===== hdl/ipv4fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipv4fct_ctrl
// Sequencer: setup, bitmap word scan and pipeline flush (adds only), report.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4fct_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  output logic                   report,
  output ipv4fct_pkg::ctrl_cmd_t cmd,
  input  ipv4fct_pkg::ctrl_sts_t sts
);
  import ipv4fct_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SETUP  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_FLUSH  = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  state_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (start) st_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        st_nxt = sts.op_clear ? ST_REPORT : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.rd_last) st_nxt = ST_FLUSH;
      end
      ST_FLUSH:  st_nxt = ST_REPORT;
      ST_REPORT: st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign busy      = (st_r != ST_IDLE);
  assign report    = (st_r == ST_REPORT);
  assign cmd.load  = (st_r == ST_IDLE) && start;
  assign cmd.setup = (st_r == ST_SETUP);
  assign cmd.rd    = (st_r == ST_SCAN);

  `CHK_PROP(a_report_single, clk, rst_n, report |=> !report)
  `CHK_PROP(a_accept_busy, clk, rst_n, (start && !busy) |=> busy)
  `CHK_PROP(a_scan_stops, clk, rst_n, (cmd.rd && sts.rd_last) |=> !cmd.rd)

endmodule

// ===== hdl/ipv4fct_dpath.sv =====
// ----------------------------------------------------------------------------
// ipv4fct_dpath
// Length checks, last byte register and the bitmap memory with its
// read-modify-write and completeness check pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4fct_dpath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ipv4fct_pkg::ctrl_cmd_t cmd,
  output ipv4fct_pkg::ctrl_sts_t sts,
  input  logic                   in_op,
  input  logic [15:0]            in_frame_len,
  input  logic [15:0]            in_ip_total_length,
  input  logic [5:0]             in_ip_header_length,
  input  logic [15:0]            in_fragment_offset,
  input  logic                   in_more_fragments,
  output logic                   out_accepted,
  output logic                   out_complete,
  output logic [15:0]            out_last_byte
);
  import ipv4fct_pkg::*;

  // Captured item fields.
  logic        op_r;
  logic [15:0] frame_r, total_r, offset_r;
  logic [5:0]  hdr_r;
  logic        mf_r;

  // Per-item results of setup.
  logic              acc_r;
  logic [LO_W-1:0]   lo_r;
  logic [HI_W-1:0]   hi_r;
  logic [HI_W-1:0]   need_r;
  logic              need_ok_r;
  logic [15:0]       final_r;

  // Bitmap storage and scan pipeline.
  logic [WORD_BITS-1:0]    mem_r [BITMAP_WORDS];
  logic [BITMAP_WORDS-1:0] valid_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic [IDX_W-1:0]        chk_idx_r;
  logic                    chk_en_r;
  logic [WORD_BITS-1:0]    mem_q_r;
  logic                    vld_q_r;
  logic                    all_ok_r;

  // Setup arithmetic.
  logic        op_clear;
  logic        len_ok;
  logic [15:0] pay_m1;
  logic [16:0] last17;
  logic        good;
  logic [15:0] final_nxt;
  logic [16:0] end_excl;
  logic [16:0] need_end;

  // Scan arithmetic.
  logic [WCMP_W-1:0]    w_cmp;
  logic [WORD_BITS-1:0] fill_mask, req_mask, old_word, new_word;
  logic                 mem_we;

  assign op_clear = (op_r == OP_CLEAR);

  assign len_ok = (frame_r >= MIN_FRAME_BYTES) && (total_r > {10'd0, hdr_r}) &&
                  ({1'b0, total_r} + {1'b0, ETH_HDR_BYTES} <= {1'b0, frame_r});
  assign pay_m1 = total_r - {10'd0, hdr_r} - 16'd1;
  assign last17 = {1'b0, pay_m1} + {1'b0, offset_r};
  assign good   = !op_clear && len_ok && !last17[16];

  always_comb begin
    final_nxt = final_r;
    if (op_clear) begin
      final_nxt = UNKNOWN_LAST;
    end else if (good && !mf_r && (final_r > last17[15:0])) begin
      final_nxt = last17[15:0];
    end
  end

  assign end_excl = last17 + 17'd1;
  assign need_end = {1'b0, final_nxt} + 17'd1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      frame_r  <= in_frame_len;
      total_r  <= in_ip_total_length;
      hdr_r    <= in_ip_header_length;
      offset_r <= in_fragment_offset;
      mf_r     <= in_more_fragments;
    end
    if (cmd.setup) begin
      acc_r     <= good;
      lo_r      <= offset_r[15:BLK_SHIFT];
      hi_r      <= end_excl[16:BLK_SHIFT];
      need_r    <= need_end[16:BLK_SHIFT];
      need_ok_r <= (final_nxt != UNKNOWN_LAST) &&
                   (need_end[16:BLK_SHIFT] <= HI_W'(BITMAP_BLOCKS));
    end
  end

  // Read pointer of the scan.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rd_idx_r <= '0;
    end else if (cmd.rd) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
  end

  assign sts.op_clear = op_clear;
  assign sts.rd_last  = (rd_idx_r == IDX_W'(BITMAP_WORDS - 1));

  // Check stage: merge the fragment's blocks into the word just read and
  // test the merged word against the blocks that completion needs.
  assign w_cmp     = WCMP_W'(chk_idx_r);
  assign fill_mask = ones_below(bound_span(w_cmp, hi_r[HI_W-1:BIT_POS_W],
                                           hi_r[BIT_POS_W-1:0])) &
                     ~ones_below(bound_span(w_cmp, WCMP_W'(lo_r[LO_W-1:BIT_POS_W]),
                                            lo_r[BIT_POS_W-1:0]));
  assign req_mask  = ones_below(bound_span(w_cmp, need_r[HI_W-1:BIT_POS_W],
                                           need_r[BIT_POS_W-1:0]));
  assign old_word  = vld_q_r ? mem_q_r : '0;
  assign new_word  = old_word | (acc_r ? fill_mask : '0);
  assign mem_we    = chk_en_r && acc_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[chk_idx_r] <= new_word;
    end
    if (cmd.rd) begin
      mem_q_r   <= mem_r[rd_idx_r];
      vld_q_r   <= valid_r[rd_idx_r];
      chk_idx_r <= rd_idx_r;
    end
    if (cmd.setup) begin
      all_ok_r <= 1'b1;
    end else if (chk_en_r) begin
      all_ok_r <= all_ok_r && ((new_word & req_mask) == req_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      final_r  <= UNKNOWN_LAST;
      chk_en_r <= 1'b0;
    end else begin
      chk_en_r <= cmd.rd;
      if (cmd.setup) begin
        final_r <= final_nxt;
      end
      if (cmd.setup && op_clear) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[chk_idx_r] <= 1'b1;
      end
    end
  end

  assign out_accepted  = acc_r;
  assign out_complete  = need_ok_r && all_ok_r;
  assign out_last_byte = final_r;

  `CHK_PROP(a_complete_known, clk, rst_n,
            (need_ok_r && all_ok_r) |-> (final_r != UNKNOWN_LAST))
  `CHK_PROP(a_last_only_falls, clk, rst_n,
            ($past(rst_n) && !$past(cmd.setup && op_clear) &&
             (final_r != $past(final_r))) |-> (final_r < $past(final_r)))
  `CHK_PROP(a_scan_ends_last, clk, rst_n,
            (chk_en_r && !cmd.rd) |-> (chk_idx_r == IDX_W'(BITMAP_WORDS - 1)))

endmodule

// ===== hdl/ipv4_fragment_coverage_tracker.sv =====
// ----------------------------------------------------------------------------
// ipv4_fragment_coverage_tracker
// Sequence: an add item runs setup, reads of all bitmap words, a flush and
// report; a clear runs setup and report. The scan reads one bitmap word
// per cycle from one RAM port, and a new item is taken only after the
// previous one has reported. Results cannot be stalled. Synchronous reset
// empties the bitmap at once.
// ----------------------------------------------------------------------------
// Tracks which 8-byte payload blocks of one IPv4 datagram have arrived.
//
// A clear item starts a new datagram: the bitmap valid bits drop at setup,
// so every word reads as zero until it is written again, and the known last
// payload byte returns to 65535 (unknown). The result is accepted=0,
// complete=0, last_byte=65535.
//
// An add item is checked against the frame and header lengths. A good
// fragment marks every block from the one holding its first byte up to the
// last block it covers in full, and a final fragment (MF clear) lowers the
// last byte. A bad fragment changes nothing but still reports the current completion status.
//
// The datagram is complete when the last byte is known and every block below
// (last_byte+1)/8 is marked. After an add item's setup, the controller walks
// all bitmap words in order. Each word is read, merged with the fragment's
// block mask, written back and tested against the blocks completion requires,
// all in one combined pass, so the status reflects the item's own update.
//
// The handshake is a command style: an item is taken when start is high and
// busy is low, and each item returns exactly one result on the out_ ports,
// marked by out_valid for one cycle.
// ----------------------------------------------------------------------------
module ipv4_fragment_coverage_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [15:0] in_frame_len,
  input  logic [15:0] in_ip_total_length,
  input  logic [5:0]  in_ip_header_length,
  input  logic [15:0] in_fragment_offset,
  input  logic        in_more_fragments,
  output logic        out_valid,
  output logic        out_accepted,
  output logic        out_complete,
  output logic [15:0] out_last_byte
);
  import ipv4fct_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The sequencer owns the handshake and the scan timing.
  ipv4fct_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .report (out_valid),
    .cmd    (cmd),
    .sts    (sts)
  );

  // The datapath holds the item, the last byte, and the bitmap memory.
  // Its result registers stay stable from the end of the flush (of setup, for
  // a clear) through the report cycle.
  ipv4fct_dpath u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_frame_len        (in_frame_len),
    .in_ip_total_length  (in_ip_total_length),
    .in_ip_header_length (in_ip_header_length),
    .in_fragment_offset  (in_fragment_offset),
    .in_more_fragments   (in_more_fragments),
    .out_accepted        (out_accepted),
    .out_complete        (out_complete),
    .out_last_byte       (out_last_byte)
  );

endmodule
